// ===== sv/small_set_table_assert.svh =====
// Assertion macros used by the set table top level.
`ifndef SMALL_SET_TABLE_ASSERT_SVH
`define SMALL_SET_TABLE_ASSERT_SVH

// Checked on every rising edge outside of reset.
`define SST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("set table assertion failed");

// Checked on every rising edge, reset included.
`define SST_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("set table invariant failed");

`endif

// ===== sv/sst_pkg.sv =====
`default_nettype none
package sst_pkg;

  // Number of entries the set can hold.
  localparam int unsigned DEPTH = 16;
  // Width of an entry index and of the element count.
  localparam int unsigned IdxW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  // Fixed field widths of the result.
  localparam int unsigned ValW  = 32;
  localparam int unsigned PosW  = 4;
  localparam int unsigned StatW = 2;
  localparam int unsigned CntFW = 5;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_LOOKUP = 2'd3
  } sst_req_e;

  typedef enum logic [StatW-1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2,
    ST_MISS = 2'd3
  } sst_status_e;

  // Update command broadcast to every cell of the row.
  typedef struct packed {
    logic            ins_en;
    logic            rem_en;
    logic [IdxW-1:0] rem_pos;
    logic [CntW-1:0] count;
    logic [ValW-1:0] value;
  } sst_ctrl_t;

endpackage
`default_nettype wire

// ===== sv/sst_cell.sv =====
`default_nettype none
// One entry of the set: holds a value, compares it with the request and
// takes its upper neighbor's value when an entry at or below it is removed.
module sst_cell
  import sst_pkg::*;
(
  input  wire              clk_i,
  input  wire [IdxW-1:0]   index_i,
  input  wire sst_ctrl_t   ctrl_i,
  input  wire [ValW-1:0]   next_data_i,
  output logic [ValW-1:0]  data_o,
  output logic             hit_o
);

  logic [ValW-1:0] data_q, data_d;
  logic [CntW-1:0] index_ext;
  logic            live;

  assign index_ext = CntW'(index_i);
  assign live      = index_ext < ctrl_i.count;

  // Match only on entries below the count.
  assign hit_o  = live && (data_q == ctrl_i.value);
  assign data_o = data_q;

  // Append lands at the count; removal pulls later entries down by one.
  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins_en && (index_ext == ctrl_i.count)) begin
      data_d = ctrl_i.value;
    end else if (ctrl_i.rem_en && (index_i >= ctrl_i.rem_pos) &&
                 ((index_ext + CntW'(1)) < ctrl_i.count)) begin
      data_d = next_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule
`default_nettype wire

// ===== sv/small_set_table.sv =====
// Small ordered set of up to DEPTH distinct signed 32-bit values, kept in
// arrival order in a row of entry cells. A request (tuser: 0 clear, 1 insert,
// 2 remove, 3 lookup) is compared against all live entries in the cycle it
// is accepted, the set is updated at that same edge, and one result follows
// in the output register on the next cycle. The block takes one request per
// clock; the figure is set by the combinational compare across the cell row
// and the one-step shift that closes the gap after a removal. The input
// stalls only while a result waits in the output register and the sink is
// not ready. Entries above the count are never read, so no clearing is
// needed after reset.
`default_nettype none
`include "small_set_table_assert.svh"
module small_set_table
  import sst_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,  // [31:0] value
  input  wire  [1:0]  s_axis_tuser,  // [1:0] req_type
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [15:0] m_axis_tdata   // [0] found, [4:1] position,
                                     // [6:5] status, [11:7] count, rest zero
);

  logic [CntW-1:0]  count_q, count_d;
  logic             out_valid_q;
  logic [15:0]      out_data_q;
  logic             in_acc;
  sst_req_e         req;
  sst_ctrl_t        ctrl;
  logic [DEPTH-1:0] hit;
  logic [ValW-1:0]  cell_data [DEPTH];
  logic             found;
  logic [IdxW-1:0]  pos;
  logic             full;
  sst_status_e      status;
  logic [CntFW-1:0] count_f;
  logic [PosW-1:0]  pos_f;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign req           = sst_req_e'(s_axis_tuser);
  assign full          = count_q >= CntW'(DEPTH);

  // Match summary: entries are distinct, so at most one cell hits.
  always_comb begin
    pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (hit[i]) pos = pos | IdxW'(i);
    end
  end
  assign found = |hit;

  // Decide the update and the status of this request.
  always_comb begin
    ctrl.ins_en  = 1'b0;
    ctrl.rem_en  = 1'b0;
    ctrl.rem_pos = pos;
    ctrl.count   = count_q;
    ctrl.value   = s_axis_tdata;
    count_d      = count_q;
    status       = ST_OK;
    case (req)
      REQ_CLEAR: begin
        count_d = '0;
      end
      REQ_INSERT: begin
        if (found) begin
          status = ST_DUP;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          ctrl.ins_en = in_acc;
          count_d     = count_q + CntW'(1);
        end
      end
      REQ_REMOVE: begin
        if (!found) begin
          status = ST_MISS;
        end else begin
          ctrl.rem_en = in_acc;
          count_d     = count_q - CntW'(1);
        end
      end
      REQ_LOOKUP: begin
        if (!found) status = ST_MISS;
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  // Row of entry cells, each fed by its upper neighbor.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [ValW-1:0] next_data;
    if (g == DEPTH - 1) begin : g_last
      assign next_data = '0;
    end else begin : g_mid
      assign next_data = cell_data[g+1];
    end
    sst_cell u_cell (
      .clk_i       (clk_i),
      .index_i     (IdxW'(g)),
      .ctrl_i      (ctrl),
      .next_data_i (next_data),
      .data_o      (cell_data[g]),
      .hit_o       (hit[g])
    );
  end

  assign count_f = CntFW'(count_d);
  assign pos_f   = (req == REQ_CLEAR) ? '0 : PosW'(pos);

  // Element count and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= {4'b0, count_f, status, pos_f, found && (req != REQ_CLEAR)};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Checks on the count and on the compare row.
  `SST_ASSERT_ALWAYS(a_count_bound, (!rst_ni) || (count_q <= CntW'(DEPTH)))
  `SST_ASSERT(a_single_hit, $onehot0(hit))
  `SST_ASSERT(a_insert_grows,
    (in_acc && req == REQ_INSERT && !found && !full) |=>
      (count_q == $past(count_q) + CntW'(1)))
  `SST_ASSERT(a_remove_shrinks,
    (in_acc && req == REQ_REMOVE && found) |=>
      (count_q == $past(count_q) - CntW'(1)))

endmodule
`default_nettype wire
